[sv/dbd_pkg.sv]
`timescale 1ns / 1ps
package dbd_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int COUNT_W = 22;
    localparam int NUM_W   = 24;
    localparam int POS_W   = 10;
    localparam int BEF_W   = 23;
    localparam int IN_W    = 48;
    localparam int OUT_W   = 24;

    localparam logic [12:0] DIV25_MUL   = 13'd5243;
    localparam int          DIV25_SHIFT = 17;

    typedef logic [NUM_W-1:0] t_day_num;

    function automatic logic [POS_W-1:0] month_start(input logic [MONTH_W-1:0] m);
        logic [POS_W-1:0] v;
        case (m)
            4'd0:    v = 10'h3E1;
            4'd1:    v = 10'd0;
            4'd2:    v = 10'd31;
            4'd3:    v = 10'd59;
            4'd4:    v = 10'd90;
            4'd5:    v = 10'd120;
            4'd6:    v = 10'd151;
            4'd7:    v = 10'd181;
            4'd8:    v = 10'd212;
            4'd9:    v = 10'd243;
            4'd10:   v = 10'd273;
            4'd11:   v = 10'd304;
            default: v = 10'd334;
        endcase
        return v;
    endfunction

endpackage

[sv/dbd_day_num.sv]
`timescale 1ns / 1ps
module dbd_day_num (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [dbd_pkg::YEAR_W-1:0]     i_year,
    input  logic [dbd_pkg::MONTH_W-1:0]    i_month,
    input  logic [dbd_pkg::DAY_W-1:0]      i_day,
    output dbd_pkg::t_day_num              o_num
);

    logic [12:0] w_x100;
    logic [10:0] w_x400;
    logic [11:0] w_y4;
    logic [9:0]  w_y16;

    logic [22:0] r_y365;
    logic [12:0] r_u4;
    logic [25:0] r_q100;
    logic [23:0] r_q400;
    logic [24:0] r_qy4;
    logic [22:0] r_qy16;
    logic [11:0] r_y4;
    logic [9:0]  r_y16;
    logic [dbd_pkg::POS_W-1:0] r_base;
    logic        r_ge3;
    logic        r_mod4;

    logic [8:0]  w_c100;
    logic [6:0]  w_c400;
    logic [7:0]  w_q4;
    logic [5:0]  w_q16;
    logic [11:0] w_q4x25;
    logic [9:0]  w_q16x25;
    logic        w_leap;

    logic [dbd_pkg::BEF_W-1:0] r_before;
    logic [dbd_pkg::POS_W-1:0] r_pos;
    dbd_pkg::t_day_num         r_num;

    assign w_x100 = 13'((15'(i_year) + 15'd99) >> 2);
    assign w_x400 = 11'((15'(i_year) + 15'd399) >> 4);
    assign w_y4   = i_year[13:2];
    assign w_y16  = i_year[13:4];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_y365 <= 23'(i_year) * 23'd365;
            r_u4   <= 13'((15'(i_year) + 15'd3) >> 2);
            r_q100 <= 26'(w_x100) * 26'(dbd_pkg::DIV25_MUL);
            r_q400 <= 24'(w_x400) * 24'(dbd_pkg::DIV25_MUL);
            r_qy4  <= 25'(w_y4) * 25'(dbd_pkg::DIV25_MUL);
            r_qy16 <= 23'(w_y16) * 23'(dbd_pkg::DIV25_MUL);
            r_y4   <= w_y4;
            r_y16  <= w_y16;
            r_base <= dbd_pkg::month_start(i_month) + 10'(i_day);
            r_ge3  <= (i_month >= 4'd3);
            r_mod4 <= (i_year[1:0] == 2'd0);
        end
    end

    assign w_c100   = 9'(r_q100 >> dbd_pkg::DIV25_SHIFT);
    assign w_c400   = 7'(r_q400 >> dbd_pkg::DIV25_SHIFT);
    assign w_q4     = 8'(r_qy4 >> dbd_pkg::DIV25_SHIFT);
    assign w_q16    = 6'(r_qy16 >> dbd_pkg::DIV25_SHIFT);
    assign w_q4x25  = 12'(w_q4) * 12'd25;
    assign w_q16x25 = 10'(w_q16) * 10'd25;
    assign w_leap   = r_mod4 && ((r_y4 != w_q4x25) || (r_y16 == w_q16x25 && r_y4[1:0] == 2'd0));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_before <= r_y365 + 23'(r_u4) - 23'(w_c100) + 23'(w_c400);
            r_pos    <= r_base + 10'(w_leap && r_ge3);
            r_num    <= {1'b0, r_before} + {{(dbd_pkg::NUM_W-dbd_pkg::POS_W){r_pos[9]}}, r_pos};
        end
    end

    assign o_num = r_num;

endmodule

[sv/dbd_abs_diff.sv]
`timescale 1ns / 1ps
module dbd_abs_diff (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  dbd_pkg::t_day_num             i_num_a,
    input  dbd_pkg::t_day_num             i_num_b,
    output logic [dbd_pkg::COUNT_W-1:0]   o_count
);

    logic [dbd_pkg::NUM_W:0]     r_diff;
    logic [dbd_pkg::NUM_W:0]     w_mag;
    logic [dbd_pkg::COUNT_W-1:0] r_count;

    assign w_mag = r_diff[dbd_pkg::NUM_W] ? (~r_diff + 25'd1) : r_diff;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_diff  <= {i_num_a[dbd_pkg::NUM_W-1], i_num_a}
                     - {i_num_b[dbd_pkg::NUM_W-1], i_num_b};
            r_count <= (w_mag[dbd_pkg::NUM_W:dbd_pkg::COUNT_W] != 3'd0)
                     ? {dbd_pkg::COUNT_W{1'b1}} : w_mag[dbd_pkg::COUNT_W-1:0];
        end
    end

    assign o_count = r_count;

endmodule

[sv/days_between_dates.sv]
`timescale 1ns / 1ps
// Absolute number of days between two Gregorian dates (4/100/400 leap rule),
// zero for equal dates; the dates may come in either order and are not checked.
// A date pair is taken every cycle while s_axis_tready is high; its count
// passes through registered stages: three stages build each day number, two
// form the saturated difference, one is the output register. A two-entry
// output buffer (output register plus skid) holds results under back-pressure;
// s_axis_tready drops, and the pipeline holds, only when both entries are full.
module days_between_dates (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // year_a[13:0], month_a[17:14], day_a[22:18], year_b[36:23], month_b[40:37],
    // day_b[45:41], zero pad[47:46]
    input  logic [dbd_pkg::IN_W-1:0]    s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // day_count[21:0], zero pad[23:22]
    output logic [dbd_pkg::OUT_W-1:0]   m_axis_tdata
);

    logic                        w_en;
    logic [4:0]                  r_vld;
    dbd_pkg::t_day_num           w_num_a;
    dbd_pkg::t_day_num           w_num_b;
    logic [dbd_pkg::COUNT_W-1:0] w_count;
    logic                        r_out_vld;
    logic [dbd_pkg::COUNT_W-1:0] r_out;
    logic                        r_skid_vld;
    logic [dbd_pkg::COUNT_W-1:0] r_skid;
    logic                        w_out_free;

    assign w_en          = !r_skid_vld;
    assign s_axis_tready = w_en;
    assign w_out_free    = !r_out_vld || m_axis_tready;

    dbd_day_num u_num_a (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_year  (s_axis_tdata[13:0]),
        .i_month (s_axis_tdata[17:14]),
        .i_day   (s_axis_tdata[22:18]),
        .o_num   (w_num_a)
    );

    dbd_day_num u_num_b (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_year  (s_axis_tdata[36:23]),
        .i_month (s_axis_tdata[40:37]),
        .i_day   (s_axis_tdata[45:41]),
        .o_num   (w_num_b)
    );

    dbd_abs_diff u_diff (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_num_a (w_num_a),
        .i_num_b (w_num_b),
        .o_count (w_count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[3:0], s_axis_tvalid};
        end
    end

    // drain skid first, else take the pipeline result or park it in the skid, else retire the taken output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (w_out_free) begin
                r_out      <= r_skid;
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end
        end else if (r_vld[4]) begin
            if (w_out_free) begin
                r_out     <= w_count;
                r_out_vld <= 1'b1;
            end else begin
                r_skid     <= w_count;
                r_skid_vld <= 1'b1;
            end
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {{(dbd_pkg::OUT_W-dbd_pkg::COUNT_W){1'b0}}, r_out};

endmodule
